### src/spp_pkg.sv
// Shared types and constants for the stepper speed to timer period unit.
package spp_pkg;

    // Widths of the shared multiplier and divider
    localparam int MUL_A_W = 22;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_W   = 38;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED       = 3'd0,
        CFG_MAX_FREQ        = 3'd1,
        CFG_MIN_FREQ        = 3'd2,
        CFG_MICROSTEP       = 3'd3,
        CFG_TIMER_CLOCK     = 3'd4,
        CFG_TIMER_PRESCALER = 3'd5
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL1 = 9'b000000010,
        ST_MUL2 = 9'b000000100,
        ST_CHK1 = 9'b000001000,
        ST_DIV1 = 9'b000010000,
        ST_MUL3 = 9'b000100000,
        ST_CHK2 = 9'b001000000,
        ST_DIV2 = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### src/spp_mul.sv
// Shared multiplier with registered product.
module spp_mul (
    input  logic                         aclk,
    input  logic [spp_pkg::MUL_A_W-1:0]  op_a,
    input  logic [spp_pkg::MUL_B_W-1:0]  op_b,
    output logic [spp_pkg::MUL_P_W-1:0]  prod
);

    logic [spp_pkg::MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= spp_pkg::MUL_P_W'(op_a) * spp_pkg::MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

### src/spp_div.sv
// Shared restoring divider, one quotient bit per cycle.
module spp_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [spp_pkg::DIV_W-1:0]  dividend,
    input  logic [spp_pkg::DIV_W-1:0]  divisor,
    output logic [spp_pkg::DIV_W-1:0]  quotient,
    output spp_pkg::div_stat_t         stat
);

    localparam int DW = spp_pkg::DIV_W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DW-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
        if (fits) begin
            rem_next = diff[DW-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b1};
        end else begin
            rem_next = trial[DW-1:0];
            quo_next = {quo_reg[DW-2:0], 1'b0};
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### src/stepper_speed_to_pwm_period_unit.sv
// Top level: signed speed command in, timer reload and compare values out.
//
// Input channel s_*: one word per speed command, s_tdata[31:0] is the signed
// speed. Its sign sets the direction (zero keeps it); the magnitude is clamped
// to max_speed and scaled to a step frequency; the timer clock divided by the
// prescaler times that frequency gives the timer period.
// Output channel m_*: one word per command with direction, reload and compare
// values; tuser flags a changed period and a stopped timer.
// Configuration channel cfg_*: always ready, index selects the register, write
// only while no command is in flight.
// Sequence: the shared restoring divider runs twice per command, handing over
// each quotient when it is done, around the steps of the shared multiplier.
// A zero scaled product skips both divisions and a zero prescaler times
// frequency skips the second.
// Flow: s_tready is high only while the sequencer is idle, so no new word is
// taken before the last one is through it. A finished result waits in the output
// register while the next command is accepted and computed; a stalled receiver
// holds the sequencer in its final step until the output register frees.
// Reset: aresetn clears the sequencer, output valid, direction (forward) and
// the stored period (zero), and restores the default configuration.
module stepper_speed_to_pwm_period_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] speed_command
    // Output channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,     // [0] direction_back, [32:1] reload_value,
                                     // [63:33] compare_value
    output logic [1:0]  m_tuser,     // [0] timer_update, [1] timer_stopped
    // Configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [spp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = spp_pkg::MUL_A_W;
    localparam int BW = spp_pkg::MUL_B_W;
    localparam int PW = spp_pkg::MUL_P_W;
    localparam int DW = spp_pkg::DIV_W;

    // Configuration registers
    logic [15:0] max_speed_reg;
    logic [15:0] max_freq_reg;
    logic [15:0] min_freq_reg;
    logic [5:0]  microstep_reg;
    logic [31:0] timer_clock_reg;
    logic [15:0] timer_prescaler_reg;

    // Sequencer and working state
    spp_pkg::state_t state_reg, state_next;
    logic        dir_reg;
    logic [31:0] last_period_reg;
    logic [15:0] mag_reg;
    logic [AW-1:0] freq_reg;
    logic [31:0] period_reg;

    // Output register
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic [1:0]  m_user_reg;

    // Shared units
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [DW-1:0] div_divisor;
    logic [DW-1:0] div_quotient;
    spp_pkg::div_stat_t div_stat;

    logic        in_fire;
    logic        out_free;
    logic        raw_neg;
    logic [31:0] raw_mag;
    logic [15:0] span;
    logic        stopped;
    logic [31:0] reload;
    logic [30:0] compare;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == spp_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign raw_neg = s_tdata[31];
    assign raw_mag = raw_neg ? (32'd0 - s_tdata) : s_tdata;
    assign span    = (max_freq_reg > min_freq_reg) ? (max_freq_reg - min_freq_reg) : 16'd0;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg       <= 16'd1000;
            max_freq_reg        <= 16'd1000;
            min_freq_reg        <= 16'd0;
            microstep_reg       <= 6'd1;
            timer_clock_reg     <= 32'd84000000;
            timer_prescaler_reg <= 16'd84;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                spp_pkg::CFG_MAX_SPEED:       max_speed_reg       <= cfg_data[15:0];
                spp_pkg::CFG_MAX_FREQ:        max_freq_reg        <= cfg_data[15:0];
                spp_pkg::CFG_MIN_FREQ:        min_freq_reg        <= cfg_data[15:0];
                spp_pkg::CFG_MICROSTEP:       microstep_reg       <= cfg_data[5:0];
                spp_pkg::CFG_TIMER_CLOCK:     timer_clock_reg     <= cfg_data;
                spp_pkg::CFG_TIMER_PRESCALER: timer_prescaler_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Multiplier operand select: magnitude * microstep, then * span,
    // then frequency * prescaler
    always_comb begin
        unique case (state_reg)
            spp_pkg::ST_MUL1: begin
                mul_a = AW'(mag_reg);
                mul_b = BW'(microstep_reg);
            end
            spp_pkg::ST_MUL2: begin
                mul_a = mul_p[AW-1:0];
                mul_b = span;
            end
            default: begin
                mul_a = freq_reg;
                mul_b = timer_prescaler_reg;
            end
        endcase
    end

    spp_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // Divider: scaled product / max_speed, then clock / (prescaler * freq)
    assign div_start    = ((state_reg == spp_pkg::ST_CHK1) && (mul_p != '0)) ||
                          ((state_reg == spp_pkg::ST_CHK2) && (mul_p != '0));
    assign div_dividend = (state_reg == spp_pkg::ST_CHK1) ? DW'(mul_p) : DW'(timer_clock_reg);
    assign div_divisor  = (state_reg == spp_pkg::ST_CHK1) ? DW'(max_speed_reg) : DW'(mul_p);

    spp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spp_pkg::ST_IDLE: if (in_fire) state_next = spp_pkg::ST_MUL1;
            spp_pkg::ST_MUL1: state_next = spp_pkg::ST_MUL2;
            spp_pkg::ST_MUL2: state_next = spp_pkg::ST_CHK1;
            spp_pkg::ST_CHK1: state_next = (mul_p == '0) ? spp_pkg::ST_FIN : spp_pkg::ST_DIV1;
            spp_pkg::ST_DIV1: if (div_stat.done) state_next = spp_pkg::ST_MUL3;
            spp_pkg::ST_MUL3: state_next = spp_pkg::ST_CHK2;
            spp_pkg::ST_CHK2: state_next = (mul_p == '0) ? spp_pkg::ST_FIN : spp_pkg::ST_DIV2;
            spp_pkg::ST_DIV2: if (div_stat.done) state_next = spp_pkg::ST_FIN;
            spp_pkg::ST_FIN:  if (out_free) state_next = spp_pkg::ST_IDLE;
            default:          state_next = spp_pkg::ST_IDLE;
        endcase
    end

    // Result fields from the finished period
    assign stopped = (period_reg == 32'd0);
    assign reload  = stopped ? 32'd0 : (period_reg - 32'd1);
    assign compare = (period_reg >= 32'd2) ? (period_reg[31:1] - 31'd1) : 31'd0;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= spp_pkg::ST_IDLE;
            dir_reg         <= 1'b0;
            last_period_reg <= 32'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Zero keeps the old direction
            if (in_fire && (s_tdata != 32'd0)) begin
                dir_reg <= raw_neg;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            // Load the output word and commit the period once
            if ((state_reg == spp_pkg::ST_FIN) && out_free) begin
                m_valid_reg     <= 1'b1;
                last_period_reg <= period_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            mag_reg <= (raw_mag > 32'(max_speed_reg)) ? max_speed_reg : raw_mag[15:0];
        end
        if ((state_reg == spp_pkg::ST_DIV1) && div_stat.done) begin
            freq_reg <= div_quotient[AW-1:0];
        end
        if (((state_reg == spp_pkg::ST_CHK1) || (state_reg == spp_pkg::ST_CHK2)) &&
            (mul_p == '0)) begin
            period_reg <= 32'd0;
        end
        if ((state_reg == spp_pkg::ST_DIV2) && div_stat.done) begin
            period_reg <= div_quotient[31:0];
        end
        if ((state_reg == spp_pkg::ST_FIN) && out_free) begin
            m_data_reg <= {compare, reload, dir_reg};
            m_user_reg <= {stopped, (period_reg != last_period_reg)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTH
    // A new command blocks the input until the sequencer finishes
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted word");

    // A stopped timer carries zero reload and compare
    a_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[63:1] == 63'd0))
        else $error("stopped timer with nonzero values");

    // Compare is half the period minus one
    a_compare_half: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1] && (m_tdata[32:1] != 32'd0)) |->
        (m_tdata[63:33] == 31'((m_tdata[32:1] - 32'd1) >> 1)))
        else $error("compare value inconsistent with reload value");

    // Divider runs and finishes only while the sequencer waits for it
    a_div_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_stat.busy || div_stat.done) |-> ((state_reg == spp_pkg::ST_DIV1) ||
                                              (state_reg == spp_pkg::ST_DIV2)))
        else $error("divider active outside a division step");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for stepper_speed_to_pwm_period_unit with a built-in period predictor.
module tb;

    // Expected fields of one result word
    typedef struct packed {
        logic        dir_back;
        logic        update;
        logic        stopped;
        logic [31:0] reload;
        logic [30:0] compare;
    } timer_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // [31:0] speed_command
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;            // [0] direction_back, [32:1] reload_value,
                                     // [63:33] compare_value
    logic [1:0]  m_tuser;            // [0] timer_update, [1] timer_stopped
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [spp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Shadow of the configuration registers, reset values of the block
    logic [15:0] max_speed_q   = 16'd1000;
    logic [15:0] max_freq_q    = 16'd1000;
    logic [15:0] min_freq_q    = 16'd0;
    logic [5:0]  microstep_q   = 6'd1;
    logic [31:0] timer_clock_q = 32'd84000000;
    logic [15:0] prescaler_q   = 16'd84;

    // Predictor state
    logic        dir_back_q    = 1'b0;
    logic [31:0] last_period_q = '0;

    timer_word_t pending_timer_words[$];
    int          mismatch_count = 0;
    bit          sender_idle    = 1'b0;
    bit          receiver_idle  = 1'b0;
    int          rx_hold_req    = 0;    // long receiver hold-off, in cycles
    int          rx_stall       = 0;
    logic [31:0] last_speed     = '0;

    stepper_speed_to_pwm_period_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Advance direction and stored period for one speed command, return the expected word.
    function automatic timer_word_t predict_timer_word(logic [31:0] cmd);
        logic [31:0] mag;
        logic [63:0] span;
        logic [63:0] freq;
        logic [63:0] denom;
        logic [31:0] period;
        timer_word_t w;
        // Zero keeps the old direction
        if (cmd[31])
            dir_back_q = 1'b1;
        else if (cmd != 32'd0)
            dir_back_q = 1'b0;
        // Two's complement magnitude; the most negative command gives 2^31
        mag = cmd[31] ? (32'd0 - cmd) : cmd;
        if (mag > {16'd0, max_speed_q})
            mag = {16'd0, max_speed_q};
        period = '0;
        // A zero max_speed clamps the magnitude to zero, so no division by it
        if (mag != 32'd0) begin
            span  = (max_freq_q > min_freq_q) ? 64'(max_freq_q - min_freq_q) : 64'd0;
            freq  = (64'(mag) * 64'(microstep_q) * span) / 64'(max_speed_q);
            denom = 64'(prescaler_q) * freq;
            if (denom != 64'd0)
                period = 32'(64'(timer_clock_q) / denom);
        end
        w.dir_back = dir_back_q;
        w.update   = (period != last_period_q);
        w.stopped  = (period == 32'd0);
        if (w.update)
            last_period_q = period;
        if (period == 32'd0) begin
            w.reload  = '0;
            w.compare = '0;
        end else begin
            w.reload  = period - 32'd1;
            // A period of one clamps compare at zero
            w.compare = (period >= 32'd2) ? 31'((period >> 1) - 32'd1) : 31'd0;
        end
        return w;
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (rx_hold_req != 0) begin
            rx_stall = rx_hold_req;
            rx_hold_req <= 0;
        end else if (rx_stall == 0 && receiver_idle && $urandom_range(0, 3) == 0) begin
            rx_stall = $urandom_range(1, 8);
        end
        if (rx_stall != 0) begin
            m_tready <= 1'b0;
            rx_stall--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result word with the oldest pending expectation
    always @(posedge aclk) begin : result_check
        timer_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_timer_words.size() == 0) begin
                $error("result word with no speed command pending");
                mismatch_count++;
            end else begin
                want = pending_timer_words.pop_front();
                check_field("direction_back", 32'(want.dir_back), 32'(m_tdata[0]));
                check_field("reload_value",   want.reload,        m_tdata[32:1]);
                check_field("compare_value",  32'(want.compare),  32'(m_tdata[63:33]));
                check_field("timer_update",   32'(want.update),   32'(m_tuser[0]));
                check_field("timer_stopped",  32'(want.stopped),  32'(m_tuser[1]));
            end
        end
    end

    // Offer one speed word, with an optional gap before it; valid stays high on return.
    task automatic send_speed(logic [31:0] cmd);
        int gap;
        gap = (sender_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cmd;
        do @(posedge aclk); while (!s_tready);
        pending_timer_words.push_back(predict_timer_word(cmd));
        last_speed = cmd;
    endtask

    // Drop valid and wait for every pending result word.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_timer_words.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(spp_pkg::cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            spp_pkg::CFG_MAX_SPEED:       max_speed_q   = value[15:0];
            spp_pkg::CFG_MAX_FREQ:        max_freq_q    = value[15:0];
            spp_pkg::CFG_MIN_FREQ:        min_freq_q    = value[15:0];
            spp_pkg::CFG_MICROSTEP:       microstep_q   = value[5:0];
            spp_pkg::CFG_TIMER_CLOCK:     timer_clock_q = value;
            spp_pkg::CFG_TIMER_PRESCALER: prescaler_q   = value[15:0];
            default: ;
        endcase
    endtask

    // Drain the block, then write all six registers.
    task automatic reprogram_timer(logic [31:0] ms, logic [31:0] mf, logic [31:0] mn,
                                   logic [31:0] us, logic [31:0] clk, logic [31:0] ps);
        drain();
        write_reg(spp_pkg::CFG_MAX_SPEED, ms);
        write_reg(spp_pkg::CFG_MAX_FREQ, mf);
        write_reg(spp_pkg::CFG_MIN_FREQ, mn);
        write_reg(spp_pkg::CFG_MICROSTEP, us);
        write_reg(spp_pkg::CFG_TIMER_CLOCK, clk);
        write_reg(spp_pkg::CFG_TIMER_PRESCALER, ps);
        cfg_valid <= 1'b0;
    endtask

    // Pick a speed: mostly around the clamp limit, plus repeats and extremes
    function automatic logic [31:0] random_speed();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return last_speed;
            default: begin
                mag = $urandom_range(0, int'(max_speed_q) + int'(max_speed_q) / 4 + 1);
                return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
            end
        endcase
    endfunction

    task automatic program_random_timer();
        logic [31:0] ms, mf, mn, us, clk, ps;
        case ($urandom_range(0, 3))
            0: ms = $urandom_range(1, 64);
            1: ms = 32'd65535;
            default: ms = $urandom_range(1, 65535);
        endcase
        mf  = $urandom_range(0, 65535);
        mn  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, mf);
        us  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : (32'd1 << $urandom_range(0, 5));
        clk = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(1000000, 200000000);
        ps  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 1000);
        // Fill the unused upper bits now and then; the block must ignore them
        if ($urandom_range(0, 1) == 1) begin
            ms[31:16] = 16'($urandom);
            mf[31:16] = 16'($urandom);
            mn[31:16] = 16'($urandom);
            us[31:6]  = 26'($urandom);
            ps[31:16] = 16'($urandom);
        end
        reprogram_timer(ms, mf, mn, us, clk, ps);
    endtask

    // Reset configuration: stop, direction hold on zero, clamp, most negative command
    task automatic test_default_scaling();
        send_speed(32'd0);
        send_speed(32'd1);
        send_speed(32'd1);
        send_speed(32'hFFFF_FFFF);
        send_speed(32'd0);
        send_speed(32'd1000);
        send_speed(32'h7FFF_FFFF);
        send_speed(32'h8000_0000);
    endtask

    // Zero divisors, empty frequency span, period of one and the widest values
    task automatic test_corner_configs();
        // zero max_speed clamps everything to a stop
        reprogram_timer(0, 1000, 0, 1, 84000000, 84);
        send_speed(32'd5);
        send_speed(-32'sd5);
        // min_freq above max_freq
        reprogram_timer(1000, 100, 200, 1, 84000000, 84);
        send_speed(32'd500);
        // zero microstep
        reprogram_timer(1000, 1000, 0, 0, 84000000, 84);
        send_speed(32'd500);
        // zero prescaler
        reprogram_timer(1000, 1000, 0, 1, 84000000, 0);
        send_speed(32'd500);
        // periods of one, two and four around the compare clamp
        reprogram_timer(1, 1000, 0, 1, 1999, 1);
        send_speed(32'd1);
        send_speed(32'd0);
        reprogram_timer(1, 1000, 0, 1, 2000, 1);
        send_speed(32'd1);
        reprogram_timer(1, 1000, 0, 1, 4001, 1);
        send_speed(32'd1);
        // widest frequency with a non power of two microstep
        reprogram_timer(65535, 65535, 0, 63, 32'hFFFF_FFFF, 65535);
        send_speed(32'd65535);
        send_speed(32'd1);
        // longest possible period
        reprogram_timer(65535, 1, 0, 1, 32'hFFFF_FFFF, 1);
        send_speed(32'd65535);
    endtask

    // Hold the receiver off long enough for the input side to stall
    task automatic test_output_backpressure();
        drain();
        reprogram_timer(1000, 1000, 0, 8, 84000000, 84);
        sender_idle = 1'b0;
        rx_hold_req <= 600;
        repeat (6) send_speed(random_speed());
        drain();
    endtask

    // Random configurations, each followed by a run of random speeds
    task automatic test_random_speeds(int phases, int per_phase);
        for (int p = 0; p < phases; p++) begin
            program_random_timer();
            repeat (per_phase) send_speed(random_speed());
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        test_default_scaling();
        test_corner_configs();
        test_output_backpressure();

        sender_idle = 1'b1;
        test_random_speeds(8, 50);

        // Last part runs without idling on either side
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        test_random_speeds(1, 50);

        repeat (100) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #6000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
src/spp_pkg.sv
src/spp_mul.sv
src/spp_div.sv
src/stepper_speed_to_pwm_period_unit.sv
tb/sv/tb.sv
